// ===== rtl/core/csd_pkg.sv =====
// Shared types and constants for the compression shock detector.
// No dependencies; every module of the block imports this package.
package csd_pkg;

    // Pipeline depth from input beat to output beat
    localparam int NUM_STAGES = 7;

    // Stage indices into the per-stage enable vector
    localparam int ST_SORT   = 0;
    localparam int ST_SQUARE = 1;
    localparam int ST_SPLIT  = 2;
    localparam int ST_WEIGHT = 3;
    localparam int ST_SUM    = 4;
    localparam int ST_SCALE  = 5;
    localparam int ST_OUT    = 6;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    // Inverse spacing registers: unsigned Q16.16
    localparam int INV_W = 32;
    localparam logic [INV_W-1:0] INV_RESET = 32'h0001_0000;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_DX,
        REG_INV_DY,
        REG_INV_DZ
    } t_cfg_reg;

    localparam int NUM_AXES = 3;

    // 100*(Spost - Spre) > 33*Spre  <=>  100*Spost > 133*Spre
    localparam int POST_SCALE  = 100;
    localparam int PRE_SCALE   = 133;
    localparam int SCALE_BITS  = 8;

    localparam int OUT_TDATA_W = 8;

endpackage

// ===== rtl/core/compression_shock_detector.sv =====
// Compression shock detector, top level. An accepted beat passes the sort,
// square, split, weight, sum, scale and out stages; one cell per cycle while
// the output does not stall. Each stage holds its own valid bit and an empty
// stage keeps filling while the output stalls. Reset clears all valid bits
// and sets inv_dx, inv_dy, inv_dz to 1.0. Uses csd_pkg, csd_axis, csd_decide.
module compression_shock_detector #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave side
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // low to high: ux_plus, ux_minus, vy_plus, vy_minus, wz_plus, wz_minus
    // (DATA_WIDTH each), px_plus, px_minus, py_plus, py_minus, pz_plus,
    // pz_minus (DATA_WIDTH-1 each), zero fill
    input  logic [((12*DATA_WIDTH-6+7)/8)*8-1:0]  i_s_axis_tdata,
    // master side
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // low to high: shock_flag, compressing, zero fill
    output logic [csd_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [csd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [csd_pkg::INV_W-1:0]             i_cfg_data
);
    import csd_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int P_W    = W - 1;
    localparam int TERM_W = W + INV_W;
    localparam int WT_W   = 3 * W - 1;
    localparam int P_BASE = 2 * NUM_AXES * W;

    logic [INV_W-1:0]      r_inv [NUM_AXES];
    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    t_stage_en             stage_en;

    logic [TERM_W-1:0]     term [NUM_AXES];
    logic [NUM_AXES-1:0]   term_neg;
    logic [WT_W-1:0]       wpre [NUM_AXES];
    logic [WT_W-1:0]       wpost [NUM_AXES];
    logic                  shock;
    logic                  comp;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        stage_en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
        n_valid = r_valid;
        if (stage_en[0]) begin
            n_valid[0] = i_s_axis_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_inv[a] <= INV_RESET;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INV_DX: r_inv[0] <= i_cfg_data;
                REG_INV_DY: r_inv[1] <= i_cfg_data;
                REG_INV_DZ: r_inv[2] <= i_cfg_data;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        csd_axis #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_axis (
            .i_clk      (i_clk),
            .i_en       (stage_en),
            .i_u_plus   (i_s_axis_tdata[2*a*W +: W]),
            .i_u_minus  (i_s_axis_tdata[(2*a+1)*W +: W]),
            .i_p_plus   (i_s_axis_tdata[P_BASE + 2*a*P_W +: P_W]),
            .i_p_minus  (i_s_axis_tdata[P_BASE + (2*a+1)*P_W +: P_W]),
            .i_inv      (r_inv[a]),
            .o_term     (term[a]),
            .o_term_neg (term_neg[a]),
            .o_wpre     (wpre[a]),
            .o_wpost    (wpost[a])
        );
    end

    csd_decide #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_decide (
        .i_clk      (i_clk),
        .i_en       (stage_en),
        .i_term     (term),
        .i_term_neg (term_neg),
        .i_wpre     (wpre),
        .i_wpost    (wpost),
        .o_shock    (shock),
        .o_comp     (comp)
    );

    assign o_s_axis_tready = stage_en[0];
    assign o_m_axis_tvalid = r_valid[NUM_STAGES-1];
    assign o_m_axis_tdata  = {(OUT_TDATA_W-2)'(0), comp, shock};
    assign o_cfg_ready     = 1'b1;

endmodule

// ===== rtl/core/csd_axis.sv =====
// One axis of the detector: velocity difference, pressure sort, squared
// weight and weighted pressures over four pipeline stages. Uses csd_pkg.
module csd_axis #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  csd_pkg::t_stage_en                    i_en,
    input  logic signed [DATA_WIDTH-1:0]          i_u_plus,
    input  logic signed [DATA_WIDTH-1:0]          i_u_minus,
    input  logic        [DATA_WIDTH-2:0]          i_p_plus,
    input  logic        [DATA_WIDTH-2:0]          i_p_minus,
    input  logic        [csd_pkg::INV_W-1:0]      i_inv,
    output logic        [DATA_WIDTH+csd_pkg::INV_W-1:0] o_term,
    output logic                                  o_term_neg,
    output logic        [3*DATA_WIDTH-2:0]        o_wpre,
    output logic        [3*DATA_WIDTH-2:0]        o_wpost
);
    import csd_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int P_W    = W - 1;
    localparam int TERM_W = W + INV_W;
    localparam int E_W    = 2 * W;
    localparam int PP_W   = 2 * W - 1;
    localparam int WT_W   = 3 * W - 1;

    logic [W:0]        diff;
    logic [W:0]        diff_abs;

    // stage 1
    logic [W-1:0]      r_s1_mag;
    logic              r_s1_neg;
    logic [P_W-1:0]    r_s1_lo;
    logic [P_W-1:0]    r_s1_hi;
    // stage 2
    logic [TERM_W-1:0] r_s2_term;
    logic [E_W-1:0]    r_s2_e;
    logic              r_s2_neg;
    logic [P_W-1:0]    r_s2_lo;
    logic [P_W-1:0]    r_s2_hi;
    // stage 3
    logic [PP_W-1:0]   r_s3_lo_l;
    logic [PP_W-1:0]   r_s3_lo_h;
    logic [PP_W-1:0]   r_s3_hi_l;
    logic [PP_W-1:0]   r_s3_hi_h;
    // stage 4
    logic [WT_W-1:0]   r_s4_wpre;
    logic [WT_W-1:0]   r_s4_wpost;

    always_comb begin
        diff     = {i_u_plus[W-1], i_u_plus} - {i_u_minus[W-1], i_u_minus};
        diff_abs = diff[W] ? (~diff + (W+1)'(1)) : diff;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_SORT]) begin
            r_s1_mag <= diff_abs[W-1:0];
            r_s1_neg <= diff[W];
            r_s1_lo  <= (i_p_plus < i_p_minus) ? i_p_plus : i_p_minus;
            r_s1_hi  <= (i_p_plus < i_p_minus) ? i_p_minus : i_p_plus;
        end
        if (i_en[ST_SQUARE]) begin
            r_s2_term <= TERM_W'(r_s1_mag) * TERM_W'(i_inv);
            r_s2_e    <= E_W'(r_s1_mag) * E_W'(r_s1_mag);
            r_s2_neg  <= r_s1_neg;
            r_s2_lo   <= r_s1_lo;
            r_s2_hi   <= r_s1_hi;
        end
        // split the squared weight into halves to keep each product narrow
        if (i_en[ST_SPLIT]) begin
            r_s3_lo_l <= PP_W'(r_s2_e[W-1:0]) * PP_W'(r_s2_lo);
            r_s3_lo_h <= PP_W'(r_s2_e[E_W-1:W]) * PP_W'(r_s2_lo);
            r_s3_hi_l <= PP_W'(r_s2_e[W-1:0]) * PP_W'(r_s2_hi);
            r_s3_hi_h <= PP_W'(r_s2_e[E_W-1:W]) * PP_W'(r_s2_hi);
        end
        if (i_en[ST_WEIGHT]) begin
            r_s4_wpre  <= WT_W'(r_s3_lo_l) + (WT_W'(r_s3_lo_h) << W);
            r_s4_wpost <= WT_W'(r_s3_hi_l) + (WT_W'(r_s3_hi_h) << W);
        end
    end

    assign o_term     = r_s2_term;
    assign o_term_neg = r_s2_neg;
    assign o_wpre     = r_s4_wpre;
    assign o_wpost    = r_s4_wpost;

endmodule

// ===== rtl/core/csd_decide.sv =====
// Divergence sign and pressure jump test across the three axes, ending in
// the output register. Uses csd_pkg; fed by three csd_axis instances.
module csd_decide #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  csd_pkg::t_stage_en                    i_en,
    input  logic [DATA_WIDTH+csd_pkg::INV_W-1:0]  i_term [csd_pkg::NUM_AXES],
    input  logic [csd_pkg::NUM_AXES-1:0]          i_term_neg,
    input  logic [3*DATA_WIDTH-2:0]               i_wpre [csd_pkg::NUM_AXES],
    input  logic [3*DATA_WIDTH-2:0]               i_wpost [csd_pkg::NUM_AXES],
    output logic                                  o_shock,
    output logic                                  o_comp
);
    import csd_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int TERM_W = W + INV_W;
    localparam int DIV_W  = TERM_W + 3;
    localparam int S_W    = 3 * W + 1;
    localparam int SC_W   = S_W + SCALE_BITS;

    logic [DIV_W-1:0] div_sum;
    logic [S_W-1:0]   pre_sum;
    logic [S_W-1:0]   post_sum;

    logic             r_s3_comp;
    logic             r_s4_comp;
    logic             r_s5_comp;
    logic [S_W-1:0]   r_s5_spre;
    logic [S_W-1:0]   r_s5_spost;
    logic             r_s6_comp;
    logic             r_s6_nz;
    logic [SC_W-1:0]  r_s6_pre;
    logic [SC_W-1:0]  r_s6_post;
    logic             r_s7_shock;
    logic             r_s7_comp;

    always_comb begin
        div_sum = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            if (i_term_neg[a]) begin
                div_sum = div_sum - DIV_W'(i_term[a]);
            end else begin
                div_sum = div_sum + DIV_W'(i_term[a]);
            end
        end
    end

    always_comb begin
        pre_sum  = '0;
        post_sum = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            pre_sum  = pre_sum + S_W'(i_wpre[a]);
            post_sum = post_sum + S_W'(i_wpost[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_SPLIT]) begin
            r_s3_comp <= div_sum[DIV_W-1];
        end
        if (i_en[ST_WEIGHT]) begin
            r_s4_comp <= r_s3_comp;
        end
        if (i_en[ST_SUM]) begin
            r_s5_comp  <= r_s4_comp;
            r_s5_spre  <= pre_sum;
            r_s5_spost <= post_sum;
        end
        if (i_en[ST_SCALE]) begin
            r_s6_comp <= r_s5_comp;
            r_s6_nz   <= (r_s5_spre != '0);
            r_s6_pre  <= SC_W'(r_s5_spre) * SC_W'(PRE_SCALE);
            r_s6_post <= SC_W'(r_s5_spost) * SC_W'(POST_SCALE);
        end
        if (i_en[ST_OUT]) begin
            r_s7_comp  <= r_s6_comp;
            r_s7_shock <= r_s6_comp && r_s6_nz && (r_s6_post > r_s6_pre);
        end
    end

    assign o_shock = r_s7_shock;
    assign o_comp  = r_s7_comp;

endmodule

// ===== tb/sv/csd_checker.sv =====
// Output checker for the compression shock detector testbench.
// Watches the cell, flag and configuration channels, works out the flags of every
// accepted cell beat and compares them with the output beats. Depends on csd_pkg.
module csd_flag_checker #(
    parameter int DW   = 32,
    parameter int IN_W = ((12*DW-6+7)/8)*8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [IN_W-1:0]                   i_s_tdata,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [csd_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [csd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [csd_pkg::INV_W-1:0]         i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);
    import csd_pkg::*;

    localparam int PW        = DW - 1;
    localparam int OUT_SHOCK = 0;
    localparam int OUT_COMP  = 1;

    logic [NUM_AXES-1:0][INV_W-1:0] spacing;
    logic [1:0]                     flags_due_q [$];
    logic [1:0]                     want;
    int                             mismatches = 0;

    // Flags of one cell: bit OUT_SHOCK is the shock flag, bit OUT_COMP the sign test
    function automatic logic [1:0] shock_flags_of(input logic [IN_W-1:0] item,
                                                  input logic [NUM_AXES-1:0][INV_W-1:0] inv);
        logic signed [DW:0] du;
        logic [DW:0]        mag;
        logic [PW-1:0]      pa, pb, plo, phi;
        logic [127:0]       pos_sum, neg_sum, pre_sum, post_sum, sq;
        logic [1:0]         flags;
        pos_sum  = '0;
        neg_sum  = '0;
        pre_sum  = '0;
        post_sum = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            du  = $signed(item[DW*2*a +: DW]) - $signed(item[DW*(2*a+1) +: DW]);
            mag = du[DW] ? -du : du;
            pa  = item[6*DW + PW*2*a +: PW];
            pb  = item[6*DW + PW*(2*a+1) +: PW];
            plo = (pa < pb) ? pa : pb;
            phi = (pa < pb) ? pb : pa;
            if (du[DW])
                neg_sum = neg_sum + 128'(mag) * 128'(inv[a]);
            else
                pos_sum = pos_sum + 128'(mag) * 128'(inv[a]);
            sq       = 128'(mag) * 128'(mag);
            pre_sum  = pre_sum + sq * 128'(plo);
            post_sum = post_sum + sq * 128'(phi);
        end
        flags[OUT_COMP]  = neg_sum > pos_sum;
        flags[OUT_SHOCK] = flags[OUT_COMP] && (pre_sum != 0) &&
                           (post_sum * 128'(POST_SCALE) > pre_sum * 128'(PRE_SCALE));
        return flags;
    endfunction

    task automatic note_mismatch(input string what, input logic exp_v, input logic act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected %0b, got %0b", $time, what, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            spacing = {NUM_AXES{INV_RESET}};
        end else begin
            // indexes beyond the last axis are dropped, as in the block
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NUM_AXES)
                spacing[i_cfg_index] = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                flags_due_q.push_back(shock_flags_of(i_s_tdata, spacing));
            if (i_m_tvalid && i_m_tready) begin
                if (flags_due_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: output beat %0h with no cell waiting", $time, i_m_tdata);
                end else begin
                    want = flags_due_q.pop_front();
                    if (want[OUT_SHOCK] !== i_m_tdata[OUT_SHOCK])
                        note_mismatch("shock_flag", want[OUT_SHOCK], i_m_tdata[OUT_SHOCK]);
                    if (want[OUT_COMP] !== i_m_tdata[OUT_COMP])
                        note_mismatch("compressing", want[OUT_COMP], i_m_tdata[OUT_COMP]);
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= flags_due_q.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the compression shock detector: clock, reset, cell and
// configuration stimulus, output back-pressure, watchdog and verdict.
// Depends on csd_pkg, compression_shock_detector and csd_flag_checker.
module tb;
    import csd_pkg::*;

    localparam int DW          = 32;
    localparam int PW          = DW - 1;
    localparam int IN_W        = ((12*DW-6+7)/8)*8;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = NUM_STAGES + 4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [DW-1:0] V_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] V_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [PW-1:0] P_MAX = '1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [INV_W-1:0]       cfg_data  = '0;
    int                     errors;
    int                     pending;
    int                     gap_pct    = 0;
    int                     stall_pct  = 0;
    int                     stall_left = 0;
    int                     quiet_cycles = 0;

    always #5 clk = ~clk;

    compression_shock_detector #(.DATA_WIDTH(DW)) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    csd_flag_checker #(.DW(DW), .IN_W(IN_W)) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Output back-pressure: stalls start at random with stall_pct percent odds and come in bursts
    always @(posedge clk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [IN_W-1:0] rand_beat();
        logic [IN_W-1:0] beat;
        for (int w = 0; w < IN_W / 32; w++)
            beat[32*w +: 32] = $urandom;
        return beat;
    endfunction

    function automatic logic [IN_W-1:0] pack_cell(input logic [5:0][DW-1:0] vel,
                                                  input logic [5:0][PW-1:0] prs);
        logic [IN_W-1:0] item;
        item = '0;
        for (int i = 0; i < 6; i++) begin
            item[DW*i +: DW]        = vel[i];
            item[6*DW + PW*i +: PW] = prs[i];
        end
        return item;
    endfunction

    // Mostly well-formed cells with pressure ratios near the threshold,
    // plus fully random, edge-value and two-dimensional cells
    function automatic logic [IN_W-1:0] make_cell();
        logic [5:0][DW-1:0] vel;
        logic [5:0][PW-1:0] prs;
        logic [DW-1:0]      base, step;
        logic [PW-1:0]      lo, hi;
        int                 kind;
        kind = $urandom_range(0, 9);
        for (int a = 0; a < NUM_AXES; a++) begin
            case (kind)
                0, 1: begin
                    vel[2*a]   = $urandom;
                    vel[2*a+1] = $urandom;
                    prs[2*a]   = PW'($urandom);
                    prs[2*a+1] = PW'($urandom);
                end
                8: begin
                    for (int s = 2*a; s <= 2*a+1; s++) begin
                        case ($urandom_range(0, 4))
                            0: vel[s] = V_MAX;
                            1: vel[s] = V_MIN;
                            2: vel[s] = '0;
                            3: vel[s] = '1;
                            default: vel[s] = $urandom;
                        endcase
                        case ($urandom_range(0, 3))
                            0: prs[s] = P_MAX;
                            1: prs[s] = '0;
                            2: prs[s] = PW'(1);
                            default: prs[s] = PW'($urandom);
                        endcase
                    end
                end
                default: begin
                    base = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
                    step = $urandom_range(0, 1 << 18);
                    vel[2*a+1] = base;
                    vel[2*a]   = ($urandom_range(0, 3) == 0) ? base + step : base - step;
                    lo = PW'($urandom_range(0, 1 << 24));
                    hi = ($urandom_range(0, 7) == 0) ? lo :
                         PW'(lo + lo * $urandom_range(25, 40) / 100);
                    if ($urandom_range(0, 1)) begin
                        prs[2*a]   = hi;
                        prs[2*a+1] = lo;
                    end else begin
                        prs[2*a]   = lo;
                        prs[2*a+1] = hi;
                    end
                end
            endcase
        end
        if (kind == 7) begin
            vel[5] = vel[4];
            prs[5] = prs[4];
        end
        return pack_cell(vel, prs);
    endfunction

    // Hold valid high across back-to-back beats; drop it only for a gap
    task automatic offer_cell(input logic [IN_W-1:0] item);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= rand_beat();
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_fields(input logic [DW-1:0] uxp, uxm, vyp, vym, wzp, wzm,
                               input logic [PW-1:0] pxp, pxm, pyp, pym, pzp, pzm);
        offer_cell(pack_cell({wzm, wzp, vym, vyp, uxm, uxp}, {pzm, pzp, pym, pyp, pxm, pxp}));
    endtask

    task automatic wait_drain();
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [INV_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write all spacings while the pipeline is empty, plus one ignored index
    task automatic program_spacing(input logic [INV_W-1:0] dx, dy, dz);
        s_tvalid <= 1'b0;
        wait_drain();
        cfg_beat(REG_INV_DX, dx);
        cfg_beat(REG_INV_DY, dy);
        cfg_beat(REG_INV_DZ, dz);
        cfg_beat(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        gap_pct   = 25;
        stall_pct = 20;

        // directed cells under the reset spacing
        send_fields('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        send_fields(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX,
                    P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX);
        send_fields(V_MAX, V_MIN, '0, '0, '0, '0, P_MAX, '0, '0, '0, '0, '0);
        send_fields(V_MIN, V_MAX, '0, '0, '0, '0, '0, P_MAX, '0, '0, '0, '0);
        send_fields(V_MIN, V_MAX, '0, '0, '0, '0, 31'd1, P_MAX, '0, '0, '0, '0);
        send_fields(V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX,
                    P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX);
        // ratio exactly at the threshold, then just above it, both orders
        send_fields('0, 32'd1, '0, '0, '0, '0, 31'd100, 31'd133, '0, '0, '0, '0);
        send_fields('0, 32'd1, '0, '0, '0, '0, 31'd100, 31'd134, '0, '0, '0, '0);
        send_fields('0, 32'd1, '0, '0, '0, '0, 31'd134, 31'd100, '0, '0, '0, '0);
        // divergence cancels across axes
        send_fields('0, 32'd1, 32'd1, '0, '0, '0, 31'd100, 31'd1000, '0, '0, '0, '0);
        send_fields(V_MIN, V_MAX, V_MAX, V_MIN, '0, '0, 31'd1, P_MAX, 31'd5, 31'd9, '0, '0);
        // two-dimensional cell: equal z neighbours
        send_fields(32'd10, 32'd20, 32'd5, '0, 32'd7, 32'd7,
                    31'd300, 31'd500, 31'd200, 31'd200, 31'd9, 31'd9);
        send_fields(32'hFFFF_FFFB, 32'hFFFF_FFFD, '0, '0, '0, '0,
                    31'd1000, 31'd2000, '0, '0, '0, '0);
        send_fields(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, V_MIN, '0,
                    31'h2AAA_AAAA, 31'h5555_5555, 31'h5555_5555, 31'h2AAA_AAAA,
                    P_MAX, 31'd1);
        send_fields('0, V_MIN, V_MIN, '0, '1, V_MAX, P_MAX, '0, '0, P_MAX, 31'd7, 31'd3);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: program_spacing('1, '1, '1);
                1: program_spacing('0, '0, '0);
                2: program_spacing($urandom, $urandom, $urandom);
                3: program_spacing(32'd1, '1, '0);
                default: program_spacing($urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20),
                                         $urandom_range(1, 1 << 20));
            endcase
            gap_pct   = $urandom_range(0, 4) * 15;
            stall_pct = $urandom_range(0, 4) * 15;
            // last stretch runs at full rate
            if (ph == 4) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            repeat (100) offer_cell(make_cell());
        end

        s_tvalid <= 1'b0;
        wait_drain();
        if (errors == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            if (pending != 0)
                $display("%0d cells never produced an output beat", pending);
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
